[rtl/spdu_pkg.sv]
package spdu_pkg;

  // number of signals of the platform; sends at or above the limit are dropped
  localparam int NUM_SIGNALS = 32;
  localparam int SIG_LIMIT   = (NUM_SIGNALS > 32) ? 32 : NUM_SIGNALS;

  localparam int SIG_W   = 5;
  localparam int STATE_W = 3;
  localparam int EXIT_W  = 8;
  localparam int PEND_W  = 31;
  localparam int DISP_W  = 64;

  localparam int QUEUE_DEPTH = 2;

  // command codes
  localparam logic [1:0] CMD_SEND      = 2'd0;
  localparam logic [1:0] CMD_DISPATCH  = 2'd1;
  localparam logic [1:0] CMD_DELIVER   = 2'd2;
  localparam logic [1:0] CMD_SET_STATE = 2'd3;

  // task states
  localparam logic [STATE_W-1:0] ST_RUNNABLE = 3'd0;
  localparam logic [STATE_W-1:0] ST_RUNNING  = 3'd1;
  localparam logic [STATE_W-1:0] ST_BLOCKED  = 3'd2;
  localparam logic [STATE_W-1:0] ST_STOPPED  = 3'd3;
  localparam logic [STATE_W-1:0] ST_ZOMBIE   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_KERNEL = 2'd1;
  localparam logic [1:0] KIND_USER   = 2'd2;

  // register indexes
  localparam logic REG_DISP = 1'b0;
  localparam logic REG_USER = 1'b1;

  // signal numbers
  localparam logic [SIG_W-1:0] SG_KILL = 5'd9;
  localparam logic [SIG_W-1:0] SG_CONT = 5'd18;

  // pending-set masks, bit n-1 for signal n
  localparam logic [PEND_W-1:0] TERM_MASK  = 31'h0000_75EF;
  localparam logic [PEND_W-1:0] STOP_MASK  = 31'h000C_0000;
  localparam logic [PEND_W-1:0] CONT_MASK  = 31'h0002_0000;
  localparam logic [PEND_W-1:0] FIXED_MASK = 31'h0004_0100;

  typedef enum logic [2:0] {
    OP_SEND,
    OP_DISPATCH,
    OP_DELIVER,
    OP_SET_STATE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SIG_W-1:0]   sig;
    logic [STATE_W-1:0] state;
  } cmd_entry_t;

  typedef struct packed {
    logic [DISP_W-1:0] disp;
    logic              user_task;
  } cfg_t;

  typedef enum logic {
    BK_IDLE,
    BK_DRAIN
  } back_state_t;

  // signal number of a one-hot pending bit
  function automatic logic [SIG_W-1:0] onehot_sig(input logic [PEND_W-1:0] onehot);
    logic [SIG_W-1:0] n;
    n = '0;
    for (int i = 0; i < PEND_W; i++) begin
      if (onehot[i]) n = n | SIG_W'(i + 1);
    end
    return n;
  endfunction

endpackage

[rtl/signal_pending_dispatch_unit_top.sv]
// channel  | handshake         | payload
// command  | start, busy       | cmd, signum, from_user_mode, new_state
// config   | wr_en             | wr_index, wr_data
// result   | valid (no stall)  | kind, sig_out, task_state_out, exit_code_out, pending_out, last
//
// a command enters a two-entry queue on start while busy is low; busy is high
// only when the queue is full
// send, set state and deliver give their one result, registered, in the cycle after leaving the queue
// dispatch walks the pending set one signal a cycle, lowest first, over up to 31 pending
// signals, and then gives the closing status beat
// synchronous active-high rst clears the pending set, task state, exit code and registers
// results appear for one cycle on valid; the receiver cannot hold them off
module signal_pending_dispatch_unit_top
  import spdu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [5:0]         signum,
  input  logic               from_user_mode,
  input  logic [STATE_W-1:0] new_state,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [DISP_W-1:0]  wr_data,
  output logic               valid,
  output logic [1:0]         kind,
  output logic [SIG_W-1:0]   sig_out,
  output logic [STATE_W-1:0] task_state_out,
  output logic [EXIT_W-1:0]  exit_code_out,
  output logic [PEND_W-1:0]  pending_out,
  output logic               last
);

  cfg_t       cfg;
  logic       push, pop, empty, full;
  cmd_entry_t entry_in, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disp      <= '0;
      cfg.user_task <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DISP: cfg.disp      <= wr_data;
        REG_USER: cfg.user_task <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign busy = full;

  spdu_front u_front (
    .start          (start),
    .full           (full),
    .cmd            (cmd),
    .signum         (signum),
    .from_user_mode (from_user_mode),
    .new_state      (new_state),
    .push           (push),
    .entry          (entry_in)
  );

  spdu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (entry_in),
    .pop       (pop),
    .entry_out (head),
    .empty     (empty),
    .full      (full)
  );

  spdu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .head           (head),
    .cfg            (cfg),
    .pop            (pop),
    .valid          (valid),
    .kind           (kind),
    .sig_out        (sig_out),
    .task_state_out (task_state_out),
    .exit_code_out  (exit_code_out),
    .pending_out    (pending_out),
    .last           (last)
  );

endmodule

[rtl/spdu_front.sv]
module spdu_front
  import spdu_pkg::*;
(
  input  logic               start,
  input  logic               full,
  input  logic [1:0]         cmd,
  input  logic [5:0]         signum,
  input  logic               from_user_mode,
  input  logic [STATE_W-1:0] new_state,
  output logic               push,
  output cmd_entry_t         entry
);

  logic sig_ok;

  assign sig_ok = (signum != 6'd0) && (signum < 6'(SIG_LIMIT));
  assign push   = start && !full;

  // commands with no effect collapse into a status-only op
  always_comb begin
    entry.sig   = signum[SIG_W-1:0];
    entry.state = new_state;
    unique case (cmd)
      CMD_SEND:      entry.op = sig_ok ? OP_SEND : OP_NOP;
      CMD_DISPATCH:  entry.op = OP_DISPATCH;
      CMD_DELIVER:   entry.op = from_user_mode ? OP_DELIVER : OP_NOP;
      CMD_SET_STATE: entry.op = (new_state <= ST_ZOMBIE) ? OP_SET_STATE : OP_NOP;
      default:       entry.op = OP_NOP;
    endcase
  end

endmodule

[rtl/spdu_queue.sv]
module spdu_queue
  import spdu_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmd_entry_t entry_in,
  input  logic       pop,
  output cmd_entry_t entry_out,
  output logic       empty,
  output logic       full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty     = (count == '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign entry_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

[rtl/spdu_back.sv]
module spdu_back
  import spdu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  cmd_entry_t         head,
  input  cfg_t               cfg,
  output logic               pop,
  output logic               valid,
  output logic [1:0]         kind,
  output logic [SIG_W-1:0]   sig_out,
  output logic [STATE_W-1:0] task_state_out,
  output logic [EXIT_W-1:0]  exit_code_out,
  output logic [PEND_W-1:0]  pending_out,
  output logic               last
);

  back_state_t        state, state_next;
  logic [PEND_W-1:0]  pending, pending_next;
  logic [STATE_W-1:0] tstate, tstate_next;
  logic [EXIT_W-1:0]  term_code, term_code_next;
  logic [PEND_W-1:0]  scan, scan_next;
  logic               valid_next;
  logic [1:0]         kind_next;
  logic [SIG_W-1:0]   sig_next;
  logic               last_next;

  logic [PEND_W-1:0]  hmask, lmask;
  logic [PEND_W-1:0]  cand, cand_lo;
  logic [PEND_W-1:0]  dcand, dcand_lo;
  logic [SIG_W-1:0]   cand_sig;
  logic               is_fixed, d_hi, d_lo, halted, drain_done;

  // per-signal disposition bits lined up with the pending set
  always_comb begin
    for (int i = 0; i < PEND_W; i++) begin
      hmask[i] = cfg.disp[2*i+3];
      lmask[i] = cfg.disp[2*i+2];
    end
  end

  assign cand       = pending & scan;
  assign cand_lo    = cand & (~cand + 1'b1);
  assign cand_sig   = onehot_sig(cand_lo);
  assign is_fixed   = |(cand_lo & FIXED_MASK);
  assign d_hi       = |(cand_lo & hmask) && !is_fixed;
  assign d_lo       = |(cand_lo & lmask) && !is_fixed;
  assign halted     = (tstate == ST_ZOMBIE) || (tstate == ST_STOPPED);
  assign drain_done = (cand == '0) || halted;

  assign dcand    = pending & ~FIXED_MASK & hmask;
  assign dcand_lo = dcand & (~dcand + 1'b1);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (!empty && head.op == OP_DISPATCH) state_next = BK_DRAIN;
      BK_DRAIN: if (drain_done) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    logic [PEND_W-1:0]  p;
    logic [PEND_W-1:0]  sbit;
    logic [STATE_W-1:0] ts;
    pending_next   = pending;
    tstate_next    = tstate;
    term_code_next = term_code;
    scan_next      = scan;
    valid_next     = 1'b0;
    kind_next      = KIND_STATUS;
    sig_next       = '0;
    last_next      = 1'b1;
    pop            = 1'b0;
    p              = pending;
    ts             = tstate;
    sbit           = PEND_W'(1) << (head.sig - 5'd1);
    unique case (state)
      BK_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          valid_next = 1'b1;
          unique case (head.op)
            OP_SEND: begin
              if (head.sig == SG_CONT) begin
                p = p & ~STOP_MASK;
                if (ts == ST_STOPPED) ts = ST_RUNNABLE;
              end else if (|(sbit & STOP_MASK)) begin
                p = p & ~CONT_MASK;
              end
              p = p | sbit;
              if (ts == ST_BLOCKED || (ts == ST_STOPPED && head.sig == SG_KILL)) begin
                ts = ST_RUNNABLE;
              end
              pending_next = p;
              tstate_next  = ts;
            end
            OP_DISPATCH: begin
              valid_next = 1'b0;
              scan_next  = '1;
            end
            OP_DELIVER: begin
              if (dcand != '0) begin
                pending_next = pending & ~dcand_lo;
                kind_next    = KIND_USER;
                sig_next     = onehot_sig(dcand_lo);
              end
            end
            OP_SET_STATE: tstate_next = head.state;
            default: ;
          endcase
        end
      end
      BK_DRAIN: begin
        if (drain_done) begin
          valid_next = 1'b1;
        end else begin
          // visit the lowest unvisited pending signal; it stays pending only for a user task with d_hi set
          scan_next = scan & ~(cand ^ (cand - 1'b1));
          if (!d_hi && !d_lo) begin
            pending_next = pending & ~cand_lo;
            if (|(cand_lo & TERM_MASK)) begin
              tstate_next    = ST_ZOMBIE;
              term_code_next = 8'd128 + EXIT_W'(cand_sig);
            end else if (|(cand_lo & STOP_MASK)) begin
              if (tstate != ST_ZOMBIE) tstate_next = ST_STOPPED;
            end
          end else if (!d_hi) begin
            pending_next = pending & ~cand_lo;
          end else if (!cfg.user_task) begin
            pending_next = pending & ~cand_lo;
            valid_next   = 1'b1;
            kind_next    = KIND_KERNEL;
            sig_next     = cand_sig;
            last_next    = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      pending   <= '0;
      tstate    <= ST_RUNNABLE;
      term_code <= '0;
      valid     <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      tstate    <= tstate_next;
      term_code <= term_code_next;
      valid     <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan    <= scan_next;
    kind    <= kind_next;
    sig_out <= sig_next;
    last    <= last_next;
  end

  assign task_state_out = tstate;
  assign exit_code_out  = term_code;
  assign pending_out    = pending;

  a_kernel_not_last: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_KERNEL |-> !last && state == BK_DRAIN)
    else $error("kernel handler beat marked last or outside drain");

  a_user_is_last: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_USER |-> last && state == BK_IDLE)
    else $error("user handler beat not final");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> state == BK_IDLE)
    else $error("final beat while drain still running");

  a_scan_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == BK_DRAIN && state_next == BK_DRAIN |=> (scan & ~$past(scan)) == '0)
    else $error("drain revisited a signal");

  a_no_pop_in_drain: assert property (@(posedge clk) disable iff (rst)
    state == BK_DRAIN |-> !pop)
    else $error("queue popped during drain");

endmodule
